/* hdl/i2cbs_pkg.sv */
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Shared codes, widths and the phase record of the I2C bit sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

    localparam int HP_W = 16;
    localparam logic [HP_W-1:0] HP_RESET = 16'd8;

    // command codes carried in the input tuser
    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_STOP  = 3'd1;
    localparam logic [2:0] ACT_ACK   = 3'd2;
    localparam logic [2:0] ACT_NACK  = 3'd3;
    localparam logic [2:0] ACT_WAIT  = 3'd4;
    localparam logic [2:0] ACT_WRITE = 3'd5;
    localparam logic [2:0] ACT_READ  = 3'd6;

    // completion status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;
    localparam logic [1:0] ST_NOACK = 2'd3;

    // one pin phase as it leaves the sequencer
    typedef struct packed {
        logic       last;
        logic [1:0] status;
        logic [7:0] rd;
        logic       sda;
        logic       scl;
    } phase_t;

endpackage

/* hdl/i2cbs_timer.sv */
// ----------------------------------------------------------------------------
// i2cbs_timer
// Phase hold counter: stays busy for the rest of a half period after a start.
// ----------------------------------------------------------------------------
module i2cbs_timer
    import i2cbs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [HP_W-1:0] ticks,
    output logic            busy
);

    logic [HP_W-1:0] count_reg;
    logic [HP_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (start)
        begin
            // a zero period holds the phase like the smallest nonzero period
            count_next = (ticks == '0) ? '0 : ticks - 1'b1;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign busy = (count_reg != '0);

endmodule

/* hdl/i2cbs_seq.sv */
// ----------------------------------------------------------------------------
// i2cbs_seq
// Command sequencer: steps through the pin phases of one command, shifting
// write bits out and SDA samples in one bit per bit period.
// ----------------------------------------------------------------------------
module i2cbs_seq
    import i2cbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] in_action,
    input  logic [7:0] in_wdata,
    input  logic [7:0] in_samples,
    output logic       out_valid,
    input  logic       out_ready,
    output phase_t     out_ph,
    input  logic       tmr_busy,
    output logic       emit
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t     state_reg;
    logic [2:0] act_reg;
    logic [7:0] wsh_reg;
    logic [7:0] ssh_reg;
    logic [7:0] rd_reg;
    logic [1:0] sub_reg;
    logic [3:0] bit_reg;
    logic       sda_drv_reg;
    logic       out_valid_reg;
    phase_t     out_ph_reg;

    phase_t     ph;
    logic       shift_w;
    logic       shift_s;
    logic       shift_rd;
    logic       bit_inc;
    logic [1:0] sub_next;
    logic       lvl;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign emit     = (state_reg == ST_RUN) && !tmr_busy && (!out_valid_reg || out_ready);
    assign lvl      = (act_reg == ACT_NACK);

    always_comb
    begin
        ph       = '0;
        shift_w  = 1'b0;
        shift_s  = 1'b0;
        shift_rd = 1'b0;
        bit_inc  = 1'b0;
        sub_next = sub_reg + 1'b1;
        case (act_reg)
            ACT_START:
            begin
                ph.scl  = 1'b1;
                shift_s = 1'b1;
                case (sub_reg)
                    2'd0:
                    begin
                        ph.sda = 1'b1;
                        if (!ssh_reg[0])
                        begin
                            ph.last   = 1'b1;
                            ph.status = ST_BUSY;
                        end
                    end
                    2'd1:
                    begin
                        if (ssh_reg[0])
                        begin
                            ph.last   = 1'b1;
                            ph.status = ST_ERROR;
                        end
                    end
                    default: ph.last = 1'b1;
                endcase
            end
            ACT_STOP:
            begin
                case (sub_reg)
                    2'd0:    ph.sda = sda_drv_reg;
                    2'd1:    ph.sda = 1'b0;
                    2'd2:    ph.scl = 1'b1;
                    default:
                    begin
                        ph.scl  = 1'b1;
                        ph.sda  = 1'b1;
                        ph.last = 1'b1;
                    end
                endcase
            end
            ACT_ACK, ACT_NACK, ACT_WAIT:
            begin
                // wait ack drives SDA released like a nack
                case (sub_reg)
                    2'd0:    ph.sda = sda_drv_reg;
                    2'd1:    ph.sda = lvl || (act_reg == ACT_WAIT);
                    2'd2:
                    begin
                        ph.scl = 1'b1;
                        ph.sda = lvl || (act_reg == ACT_WAIT);
                    end
                    default:
                    begin
                        ph.sda  = lvl || (act_reg == ACT_WAIT);
                        ph.last = 1'b1;
                        if ((act_reg == ACT_WAIT) && ssh_reg[0])
                        begin
                            ph.status = ST_NOACK;
                        end
                    end
                endcase
            end
            ACT_WRITE:
            begin
                if (bit_reg[3])
                begin
                    ph.sda  = sda_drv_reg;
                    ph.last = 1'b1;
                end
                else
                begin
                    case (sub_reg)
                        2'd0:    ph.sda = sda_drv_reg;
                        2'd1:    ph.sda = wsh_reg[7];
                        default:
                        begin
                            ph.scl   = 1'b1;
                            ph.sda   = wsh_reg[7];
                            shift_w  = 1'b1;
                            bit_inc  = 1'b1;
                            sub_next = 2'd0;
                        end
                    endcase
                end
            end
            ACT_READ:
            begin
                ph.sda = 1'b1;
                if (bit_reg[3])
                begin
                    ph.rd   = rd_reg;
                    ph.last = 1'b1;
                end
                else if (sub_reg != 2'd0)
                begin
                    ph.scl   = 1'b1;
                    shift_rd = 1'b1;
                    shift_s  = 1'b1;
                    bit_inc  = 1'b1;
                    sub_next = 2'd0;
                end
            end
            default: ph.last = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            act_reg       <= ACT_START;
            wsh_reg       <= '0;
            ssh_reg       <= '0;
            rd_reg        <= '0;
            sub_reg       <= '0;
            bit_reg       <= '0;
            sda_drv_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            out_ph_reg    <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        act_reg <= in_action;
                        wsh_reg <= in_wdata;
                        ssh_reg <= in_samples;
                        rd_reg  <= '0;
                        sub_reg <= '0;
                        bit_reg <= '0;
                        // drop unused codes without a result
                        if (in_action <= ACT_READ)
                        begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (emit)
                    begin
                        out_ph_reg    <= ph;
                        sda_drv_reg   <= ph.sda;
                        sub_reg       <= sub_next;
                        if (bit_inc)
                        begin
                            bit_reg <= bit_reg + 1'b1;
                        end
                        if (shift_w)
                        begin
                            wsh_reg <= {wsh_reg[6:0], 1'b0};
                        end
                        if (shift_s)
                        begin
                            ssh_reg <= {1'b0, ssh_reg[7:1]};
                        end
                        if (shift_rd)
                        begin
                            rd_reg <= {rd_reg[6:0], ssh_reg[0]};
                        end
                        if (ph.last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ph    = out_ph_reg;

endmodule

/* hdl/i2c_master_bit_sequencer_core.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// I2C master command engine: expands each command into timed SCL/SDA phases.
//
// Channel     Dir  Content
// s_axis      in   tuser: action[2:0]; tdata: write_data[7:0], line_samples[15:8]
// m_axis      out  tdata: scl, sda, read_data, status; tlast: last_phase
// cfg         in   cfg_we / cfg_wdata: half_period_ticks
//
// The phase hold counter spaces out the phases by half_period_ticks (zero
// acts like the smallest nonzero setting); each command expands into phases
// (write byte 25, read byte 17, stop/ack/nack/wait 4, start 1 to 3).
// A stalled m_axis holds the sequencer; it resumes when the phase is taken.
// Reset marks SDA as released and sets half_period_ticks to 8.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core
    import i2cbs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [15:0]     s_axis_tdata,  // write_data[7:0], line_samples[15:8]
    input  logic [2:0]      s_axis_tuser,  // action[2:0]
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [15:0]     m_axis_tdata,  // scl[0], sda[1], read_data[9:2], status[11:10]
    output logic            m_axis_tlast,  // last_phase
    input  logic            cfg_we,
    input  logic [HP_W-1:0] cfg_wdata
);

    logic [HP_W-1:0] half_reg;
    logic            tmr_busy;
    logic            emit;
    phase_t          ph;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HP_RESET;
        end
        else if (cfg_we)
        begin
            half_reg <= cfg_wdata;
        end
    end

    i2cbs_timer u_timer (
        .clk   (clk),
        .rst_n (rst_n),
        .start (emit),
        .ticks (half_reg),
        .busy  (tmr_busy)
    );

    i2cbs_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_action  (s_axis_tuser),
        .in_wdata   (s_axis_tdata[7:0]),
        .in_samples (s_axis_tdata[15:8]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_ph     (ph),
        .tmr_busy   (tmr_busy),
        .emit       (emit)
    );

    assign m_axis_tdata = {4'b0000, ph.status, ph.rd, ph.sda, ph.scl};
    assign m_axis_tlast = ph.last;

endmodule

/* hdl/i2cbs_checker.sv */
// ----------------------------------------------------------------------------
// i2cbs_checker
// Port-level checks of the I2C bit sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cbs_checker
    import i2cbs_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            s_axis_tready,
    input logic            m_axis_tvalid,
    input logic            m_axis_tready,
    input logic [15:0]     m_axis_tdata,
    input logic            m_axis_tlast
);

    // a pending phase stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("phase dropped while stalled");

    // status only on the final phase of a command
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[11:10] != ST_OK) |-> m_axis_tlast)
        else $error("status on a middle phase");

    // received byte only on the final phase
    a_rd_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[9:2] != 8'h00) |-> m_axis_tlast)
        else $error("read data on a middle phase");

    // no new request while a command is still mid-sequence
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready during a command");

endmodule

bind i2c_master_bit_sequencer_core i2cbs_checker u_chk (.*);

/* bench/i2cbs_phase_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbs_phase_checker
// Watches the command and phase channels of the I2C bit sequencer. Each
// accepted command is expanded into the pin phases it must produce, and every
// phase that leaves the block is compared field by field, in order.
// ----------------------------------------------------------------------------
module i2cbs_phase_checker
    import i2cbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // write_data[7:0], line_samples[15:8]
    input  logic [2:0]  s_axis_tuser,   // action[2:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // scl[0], sda[1], read_data[9:2], status[11:10]
    input  logic        m_axis_tlast,   // last_phase
    output int          fail_count,
    output int          pending,
    output int          phases_checked
);

    phase_t phase_expect[$];
    phase_t cmd_buf[25];
    phase_t want;
    int     cmd_len;
    logic   sda_now;
    int     mismatches;
    int     checked;

    task automatic add_phase(input logic scl, input logic sda);
        phase_t ph;
        ph = '0;
        ph.scl = scl;
        ph.sda = sda;
        sda_now = sda;
        cmd_buf[cmd_len] = ph;
        cmd_len = cmd_len + 1;
    endtask

    // mark the final phase and queue the whole command
    task automatic close_command(input logic [7:0] rd, input logic [1:0] st);
        phase_t ph;
        ph = cmd_buf[cmd_len - 1];
        ph.rd = rd;
        ph.status = st;
        ph.last = 1'b1;
        cmd_buf[cmd_len - 1] = ph;
        for (int i = 0; i < cmd_len; i++)
            phase_expect.push_back(cmd_buf[i]);
        cmd_len = 0;
    endtask

    task automatic expand_command(input logic [2:0] act, input logic [7:0] wd,
                                  input logic [7:0] samp);
        logic [7:0] rd;
        logic       lvl;
        rd = 8'h00;
        cmd_len = 0;
        case (act)
            ACT_START:
            begin
                add_phase(1'b1, 1'b1);
                if (!samp[0])
                    close_command(8'h00, ST_BUSY);
                else
                begin
                    add_phase(1'b1, 1'b0);
                    if (samp[1])
                        close_command(8'h00, ST_ERROR);
                    else
                    begin
                        add_phase(1'b1, 1'b0);
                        close_command(8'h00, ST_OK);
                    end
                end
            end
            ACT_STOP:
            begin
                add_phase(1'b0, sda_now);
                add_phase(1'b0, 1'b0);
                add_phase(1'b1, 1'b0);
                add_phase(1'b1, 1'b1);
                close_command(8'h00, ST_OK);
            end
            ACT_ACK, ACT_NACK:
            begin
                lvl = (act == ACT_NACK);
                add_phase(1'b0, sda_now);
                add_phase(1'b0, lvl);
                add_phase(1'b1, lvl);
                add_phase(1'b0, lvl);
                close_command(8'h00, ST_OK);
            end
            ACT_WAIT:
            begin
                add_phase(1'b0, sda_now);
                add_phase(1'b0, 1'b1);
                add_phase(1'b1, 1'b1);
                add_phase(1'b0, 1'b1);
                close_command(8'h00, samp[0] ? ST_NOACK : ST_OK);
            end
            ACT_WRITE:
            begin
                for (int i = 7; i >= 0; i--)
                begin
                    add_phase(1'b0, sda_now);
                    add_phase(1'b0, wd[i]);
                    add_phase(1'b1, wd[i]);
                end
                add_phase(1'b0, sda_now);
                close_command(8'h00, ST_OK);
            end
            ACT_READ:
            begin
                // release SDA, shift in sample k as bit 7-k
                sda_now = 1'b1;
                for (int i = 0; i < 8; i++)
                begin
                    add_phase(1'b0, 1'b1);
                    add_phase(1'b1, 1'b1);
                    rd = {rd[6:0], samp[i]};
                end
                add_phase(1'b0, 1'b1);
                close_command(rd, ST_OK);
            end
            default:
                ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            mismatches = mismatches + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_expect.delete();
            cmd_len = 0;
            sda_now = 1'b1;
            mismatches = 0;
            checked = 0;
            fail_count <= 0;
            pending <= 0;
            phases_checked <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (phase_expect.size() == 0)
                begin
                    $display("%0t: unexpected phase, expected none, actual tdata %h tlast %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = phase_expect.pop_front();
                    check_field("scl", 8'(want.scl), 8'(m_axis_tdata[0]));
                    check_field("sda", 8'(want.sda), 8'(m_axis_tdata[1]));
                    check_field("read_data", want.rd, m_axis_tdata[9:2]);
                    check_field("status", 8'(want.status), 8'(m_axis_tdata[11:10]));
                    check_field("last_phase", 8'(want.last), 8'(m_axis_tlast));
                    checked = checked + 1;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expand_command(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
            fail_count <= mismatches;
            pending <= phase_expect.size();
            phases_checked <= checked;
        end
    end

endmodule

/* bench/tb_i2c_master_bit_sequencer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_sequencer_core
// Drives commands into the I2C bit sequencer: a directed set of edge cases,
// then random bus transfers mixed with noise, under several half-period
// settings and sender/receiver idle mixes. The checker judges the phases.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_sequencer_core;
    import i2cbs_pkg::*;

    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         PHASE_CMDS  = 86;
    localparam logic [2:0] ACT_UNUSED  = 3'd7;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic [15:0]     s_axis_tdata = '0;
    logic [2:0]      s_axis_tuser = ACT_START;
    logic            m_axis_tready = 1'b0;
    logic            cfg_we = 1'b0;
    logic [HP_W-1:0] cfg_wdata = HP_RESET;
    logic            s_axis_tready;
    logic            m_axis_tvalid;
    logic [15:0]     m_axis_tdata;
    logic            m_axis_tlast;

    int fail_count;
    int pending;
    int phases_checked;
    int snd_pct = 0;
    int rcv_pct = 0;
    int cmds_sent = 0;
    int cycles = 0;
    int hp_now = int'(HP_RESET);

    int hp_list[4]  = '{1, 3, 2, 5};
    int snd_list[4] = '{0, 59, 0, 33};
    int rcv_list[4] = '{0, 0, 59, 33};

    i2c_master_bit_sequencer_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    i2cbs_phase_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .fail_count     (fail_count),
        .pending        (pending),
        .phases_checked (phases_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) < rcv_pct) ? 1'b0 : 1'b1;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d phases outstanding", cycles, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_cmd(input logic [2:0] act, input logic [7:0] wd,
                            input logic [7:0] samp);
        while ($urandom_range(99) < snd_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {samp, wd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (act != ACT_UNUSED)
            cmds_sent = cmds_sent + 1;
    endtask

    // hold the request channel until every phase is back and the block is quiet
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat ((hp_now == 0 ? 1 : hp_now) + 20)
            @(posedge clk);
    endtask

    task automatic set_half_period(input int value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value[HP_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        hp_now = value;
    endtask

    // one bus transfer: start, address, data bytes, stop; sometimes a failed start
    task automatic send_transfer();
        logic [7:0] samp;
        logic [7:0] addr;
        int         nbytes;
        samp = 8'($urandom);
        addr = 8'($urandom);
        nbytes = $urandom_range(1, 3);
        if ($urandom_range(9) == 0)
        begin
            samp[0] = 1'($urandom_range(1));
            samp[1] = samp[1] | samp[0];
            send_cmd(ACT_START, 8'($urandom), samp);
            send_cmd(ACT_STOP, 8'($urandom), 8'($urandom));
        end
        else
        begin
            samp[1:0] = 2'b01;
            send_cmd(ACT_START, 8'($urandom), samp);
            send_cmd(ACT_WRITE, addr, 8'($urandom));
            samp = 8'($urandom);
            samp[0] = ($urandom_range(4) == 0);
            send_cmd(ACT_WAIT, 8'($urandom), samp);
            for (int i = 0; i < nbytes; i++)
            begin
                if (addr[0])
                begin
                    send_cmd(ACT_READ, 8'($urandom), 8'($urandom));
                    send_cmd((i == nbytes - 1) ? ACT_NACK : ACT_ACK,
                             8'($urandom), 8'($urandom));
                end
                else
                begin
                    send_cmd(ACT_WRITE, 8'($urandom), 8'($urandom));
                    samp = 8'($urandom);
                    samp[0] = ($urandom_range(4) == 0);
                    send_cmd(ACT_WAIT, 8'($urandom), samp);
                end
            end
            send_cmd(ACT_STOP, 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        int target;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed edge cases at the reset half period
        send_cmd(ACT_START, 8'h00, 8'h01);
        send_cmd(ACT_WRITE, 8'hFF, 8'h00);
        send_cmd(ACT_WAIT, 8'h00, 8'h00);
        send_cmd(ACT_WRITE, 8'h00, 8'hFF);
        send_cmd(ACT_WAIT, 8'hFF, 8'hFF);
        send_cmd(ACT_READ, 8'hFF, 8'h00);
        send_cmd(ACT_ACK, 8'h00, 8'h00);
        send_cmd(ACT_READ, 8'h00, 8'hFF);
        send_cmd(ACT_NACK, 8'h00, 8'h00);
        send_cmd(ACT_WRITE, 8'hA5, 8'h00);
        send_cmd(ACT_READ, 8'h00, 8'h5A);
        send_cmd(ACT_ACK, 8'hFF, 8'hFF);
        send_cmd(ACT_STOP, 8'h00, 8'h00);
        send_cmd(ACT_START, 8'hFF, 8'hFE);
        send_cmd(ACT_START, 8'h00, 8'h03);
        send_cmd(ACT_UNUSED, 8'hFF, 8'hFF);
        send_cmd(ACT_STOP, 8'hFF, 8'hFF);
        send_cmd(ACT_NACK, 8'h00, 8'h00);
        send_cmd(ACT_ACK, 8'h00, 8'h00);
        send_cmd(ACT_WAIT, 8'h00, 8'h00);

        // longest half period: keep it to a few phases
        set_half_period(65535);
        send_cmd(ACT_START, 8'h00, 8'h00);
        send_cmd(ACT_START, 8'h00, 8'h03);

        // zero half period is held like the shortest nonzero one
        set_half_period(0);
        send_cmd(ACT_WRITE, 8'h3C, 8'h00);
        send_cmd(ACT_STOP, 8'h00, 8'h00);

        for (int mode = 0; mode < 4; mode++)
        begin
            set_half_period(hp_list[mode]);
            snd_pct = snd_list[mode];
            rcv_pct = rcv_list[mode];
            target = cmds_sent + PHASE_CMDS;
            while (cmds_sent < target)
            begin
                if ($urandom_range(24) == 0)
                    wait_idle();
                if ($urandom_range(99) < 15)
                    send_cmd(3'($urandom_range(7)), 8'($urandom), 8'($urandom));
                else
                    send_transfer();
            end
        end

        snd_pct = 0;
        wait_idle();
        $display("Sent %0d commands and checked %0d phases under four idle mixes",
                 cmds_sent, phases_checked);
        $display("Half periods used: 0, 1, 2, 3, 5, reset value 8 and 65535");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
